// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the ordered list engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/oal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_pkg
// Shared types and codes for the ordered list engine.
// ----------------------------------------------------------------------------
package oal_pkg;

   // Command codes
   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_FIND   = 2'd3
   } cmd_type;

   // Result status codes
   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_RANGE    = 2'd2,
      STAT_NOTFOUND = 2'd3
   } status_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_WALK = 2'd1,
      ST_FILL = 2'd2,
      ST_DONE = 2'd3
   } state_type;

   // One result item
   typedef struct packed {
      status_type         status;
      logic signed [31:0] removed_value;
      logic [7:0]         found_position;
      logic [7:0]         list_count;
   } rsp_type;

endpackage

// ===== src/oal_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_if
// Valid/ready channels for commands and results of the ordered list engine.
// ----------------------------------------------------------------------------

// Command channel
interface oal_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [7:0]         position;
   logic signed [31:0] value;

   modport source (output valid, command, position, value, input ready);
   modport sink   (input valid, command, position, value, output ready);
endinterface

// Result channel
interface oal_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] removed_value;
   logic [7:0]         found_position;
   logic [7:0]         list_count;

   modport source (output valid, status, removed_value, found_position, list_count,
                   input ready);
   modport sink   (input valid, status, removed_value, found_position, list_count,
                   output ready);
endinterface

// ===== src/ordered_array_list_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_list_engine_top
// Ordered list of signed 32-bit values kept in a single-port-read memory.
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+---------------------------------------
//   req_chan  | in  | valid / ready | command, position, value
//   rsp_chan  | out | valid / ready | status, removed_value, found_position,
//             |     |               | list_count
//
// Append and rejected commands finish without a walk; insert, delete and find
// walk the store, find stopping at the first hit. The walk reads one entry a
// cycle, then waits out read latency. Reset clears the count, the state and
// the pending and output valid flags; store contents are don't-care until written.
// A stalled result sits in the output register; the next command is taken
// while it waits and holds in its final step until the register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_array_list_engine_top #(
   parameter int LIST_DEPTH = 128
) (
   input  logic     clock,
   input  logic     reset,
   oal_req_if.sink  req_chan,
   oal_rsp_if.source rsp_chan
);
   import oal_pkg::*;

   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   logic               res_valid;
   logic               res_ready;
   rsp_type            res;
   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   logic signed [31:0] mem_wr_data;
   logic               mem_rd_en;
   logic [IDX_W-1:0]   mem_rd_addr;
   logic signed [31:0] mem_rd_data;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               slot_free;

   oal_ctrl #(
      .DEPTH (LIST_DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   oal_mem #(
      .DEPTH (LIST_DEPTH),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Output register: loads when empty or when its transfer completes
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign res_ready = slot_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_data_ff.status;
   assign rsp_chan.removed_value  = rsp_data_ff.removed_value;
   assign rsp_chan.found_position = rsp_data_ff.found_position;
   assign rsp_chan.list_count     = rsp_data_ff.list_count;

   // Checks
   `ASSERT_IMPL(a_no_accept_while_done, clock, reset,
      req_chan.valid && req_chan.ready, !res_valid)
   `ASSERT_NEXT(a_result_loads, clock, reset,
      res_valid && slot_free, rsp_valid_ff && (rsp_data_ff == $past(res)))
   `ASSERT_IMPL(a_full_means_max, clock, reset,
      rsp_valid_ff && (rsp_data_ff.status == STAT_FULL),
      rsp_data_ff.list_count == 8'(LIST_DEPTH))
   `ASSERT_IMPL(a_fail_fields_zero, clock, reset,
      rsp_valid_ff && ((rsp_data_ff.status == STAT_RANGE) ||
                       (rsp_data_ff.status == STAT_NOTFOUND)),
      (rsp_data_ff.removed_value == '0) && (rsp_data_ff.found_position == '0))

endmodule

// ===== src/oal_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module oal_mem #(
   parameter int DEPTH = 128,
   parameter int IDX_W = 7
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  logic signed [31:0] wr_data,
   input  logic               rd_en,
   input  logic [IDX_W-1:0]   rd_addr,
   output logic signed [31:0] rd_data
);

   logic signed [31:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== src/oal_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_ctrl
// Command sequencer: holds the entry count and walks the store one entry
// per cycle for insert, delete and find.
// ----------------------------------------------------------------------------
module oal_ctrl #(
   parameter int DEPTH = 128,
   parameter int IDX_W = 7,
   parameter int CNT_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   oal_req_if.sink              req_chan,
   output logic                 res_valid,
   input  logic                 res_ready,
   output oal_pkg::rsp_type     res,
   output logic                 mem_wr_en,
   output logic [IDX_W-1:0]     mem_wr_addr,
   output logic signed [31:0]   mem_wr_data,
   output logic                 mem_rd_en,
   output logic [IDX_W-1:0]     mem_rd_addr,
   input  logic signed [31:0]   mem_rd_data
);
   import oal_pkg::*;

   // Compare width wide enough for both position and count
   localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   cmd_type            cmd_ff, cmd_in;
   logic signed [31:0] val_ff, val_in;
   logic [IDX_W-1:0]   base_ff, base_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   paddr_ff, paddr_in;
   rsp_type            res_ff, res_in;

   logic [CMP_W-1:0]   pos_w;
   logic [CMP_W-1:0]   cnt_w;
   logic               full;
   logic               ins_ok;
   logic               del_ok;

   assign pos_w  = CMP_W'(req_chan.position);
   assign cnt_w  = CMP_W'(count_ff);
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign ins_ok = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1));
   assign del_ok = (pos_w != '0) && (pos_w <= cnt_w);
   assign res    = res_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      val_ff   <= val_in;
      base_ff  <= base_in;
      ptr_ff   <= ptr_in;
      left_ff  <= left_in;
      paddr_ff <= paddr_in;
      res_ff   <= res_in;
   end

   // Next state and memory control
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      cmd_in      = cmd_ff;
      val_in      = val_ff;
      base_in     = base_ff;
      ptr_in      = ptr_ff;
      left_in     = left_ff;
      pend_in     = pend_ff;
      paddr_in    = paddr_ff;
      res_in      = res_ff;
      req_chan.ready = 1'b0;
      res_valid   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               cmd_in  = cmd_type'(req_chan.command);
               val_in  = req_chan.value;
               base_in = IDX_W'(pos_w - CMP_W'(1));
               pend_in = 1'b0;
               res_in.status         = STAT_OK;
               res_in.removed_value  = '0;
               res_in.found_position = '0;
               res_in.list_count     = 8'(count_ff);
               state_in = ST_DONE;
               unique case (cmd_type'(req_chan.command))
                  CMD_APPEND: begin
                     if (full) begin
                        res_in.status = STAT_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = IDX_W'(count_ff);
                        mem_wr_data = req_chan.value;
                        count_in    = count_ff + CNT_W'(1);
                        res_in.list_count = 8'(count_ff + CNT_W'(1));
                     end
                  end
                  CMD_INSERT: begin
                     if (full) begin
                        res_in.status = STAT_FULL;
                     end else if (!ins_ok) begin
                        res_in.status = STAT_RANGE;
                     end else begin
                        // Walk down from the tail, moving each entry up one
                        ptr_in   = IDX_W'(count_ff - CNT_W'(1));
                        left_in  = CNT_W'(cnt_w - pos_w + CMP_W'(1));
                        state_in = ST_WALK;
                     end
                  end
                  CMD_DELETE: begin
                     if (!del_ok) begin
                        res_in.status = STAT_RANGE;
                     end else begin
                        // Walk up from the removed entry, moving later ones down
                        ptr_in   = IDX_W'(pos_w - CMP_W'(1));
                        left_in  = CNT_W'(cnt_w - pos_w + CMP_W'(1));
                        state_in = ST_WALK;
                     end
                  end
                  CMD_FIND: begin
                     res_in.status = STAT_NOTFOUND;
                     ptr_in   = '0;
                     left_in  = count_ff;
                     state_in = ST_WALK;
                  end
                  default: begin
                     res_in.status = STAT_OK;
                  end
               endcase
            end
         end

         ST_WALK: begin
            // Issue the next read
            if (left_ff != '0) begin
               mem_rd_en = 1'b1;
               left_in   = left_ff - CNT_W'(1);
               ptr_in    = (cmd_ff == CMD_INSERT) ? ptr_ff - IDX_W'(1)
                                                  : ptr_ff + IDX_W'(1);
               paddr_in  = ptr_ff;
               pend_in   = 1'b1;
            end else begin
               pend_in   = 1'b0;
            end

            // Consume the read data of the previous cycle
            if (pend_ff) begin
               case (cmd_ff)
                  CMD_INSERT: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = paddr_ff + IDX_W'(1);
                     mem_wr_data = mem_rd_data;
                  end
                  CMD_DELETE: begin
                     if (paddr_ff == base_ff) begin
                        res_in.removed_value = mem_rd_data;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = paddr_ff - IDX_W'(1);
                        mem_wr_data = mem_rd_data;
                     end
                  end
                  CMD_FIND: begin
                     if (mem_rd_data == val_ff) begin
                        res_in.status = STAT_OK;
                        res_in.found_position = 8'({1'b0, paddr_ff} + (IDX_W + 1)'(1));
                        pend_in  = 1'b0;
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     pend_in = 1'b0;
                  end
               endcase
            end else if (left_ff == '0) begin
               // Walk finished
               case (cmd_ff)
                  CMD_INSERT: begin
                     state_in = ST_FILL;
                  end
                  CMD_DELETE: begin
                     count_in = count_ff - CNT_W'(1);
                     res_in.list_count = 8'(count_ff - CNT_W'(1));
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_FILL: begin
            // Drop the new value into the opened slot
            mem_wr_en   = 1'b1;
            mem_wr_addr = base_ff;
            mem_wr_data = val_ff;
            count_in    = count_ff + CNT_W'(1);
            res_in.list_count = 8'(count_ff + CNT_W'(1));
            state_in    = ST_DONE;
         end

         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
